// ----- sv/fcd_pkg.sv -----
// Shared types and constants for the framed command deframer.
// Used by every module of the block but fcd_ram; depends on nothing.

package fcd_pkg;

    // Largest body the block stores for one frame
    localparam int unsigned MAX_BODY = 32;
    // Address width of one body bank and width of the body byte counter
    localparam int unsigned BODY_AW  = (MAX_BODY > 1) ? $clog2(MAX_BODY) : 1;
    localparam int unsigned CNT_W    = $clog2(MAX_BODY + 1);
    // Two banks: one being filled while the other drains
    localparam int unsigned NUM_BANKS = 2;
    localparam int unsigned RAM_DEPTH = NUM_BANKS * MAX_BODY;
    localparam int unsigned RAM_AW    = BODY_AW + 1;
    // Command queue depth between front and back
    localparam int unsigned CMDQ_DEPTH = 2;
    localparam int unsigned CMDQ_AW    = 1;

    // Framing characters
    localparam logic [7:0] CH_START = 8'h23;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_BAD_TRAILER = 2'd1,
        ST_TOO_LONG    = 2'd2,
        ST_EMPTY       = 2'd3
    } t_status;

    // One frame command handed from the parser to the output side
    typedef struct packed {
        t_status    status;
        logic [7:0] length;
        logic       bank;
    } t_cmd;

    // Bank release from the output side back to the parser
    typedef struct packed {
        logic valid;
        logic bank;
    } t_rel;

    // Body write into the bank memory
    typedef struct packed {
        logic              we;
        logic [RAM_AW-1:0] addr;
        logic [7:0]        data;
    } t_wr;

endpackage

// ----- sv/fcd_ram.sv -----
// Generic single-write, single-read RAM with registered read and read enable.
// Stand-alone; no package dependency.

module fcd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/fcd_front.sv -----
// Frame parser: accepts received bytes, stores bodies, issues frame commands.
// Depends on fcd_pkg.

module fcd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [7:0]     i_rx_byte,
    output logic           o_stall,
    input  logic           i_q_full,
    output logic           o_push,
    output fcd_pkg::t_cmd  o_cmd,
    output fcd_pkg::t_wr   o_wr,
    input  fcd_pkg::t_rel  i_rel
);

    typedef enum logic [7:0] {
        PH_START = 8'b0000_0001,
        PH_LEN   = 8'b0000_0010,
        PH_BODY  = 8'b0000_0100,
        PH_TCR   = 8'b0000_1000,
        PH_TLF   = 8'b0001_0000,
        PH_HCR   = 8'b0010_0000,
        PH_HLF   = 8'b0100_0000,
        PH_HHASH = 8'b1000_0000
    } t_phase;

    t_phase                       r_phase, n_phase;
    logic [7:0]                   r_len, n_len;
    logic [fcd_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    logic                         r_cr_ok, n_cr_ok;
    logic                         r_wbank, n_wbank;
    logic [fcd_pkg::NUM_BANKS-1:0] r_busy, n_busy;
    logic                         accept;
    logic [fcd_pkg::CNT_W-1:0]    cnt_inc;

    // Next hunt phase while searching for CR LF '#'
    function automatic t_phase hunt_next(input t_phase ph, input logic [7:0] b);
        t_phase res;
        res = PH_HCR;
        if (b == fcd_pkg::CH_CR) begin
            res = PH_HLF;
        end else if (ph == PH_HLF && b == fcd_pkg::CH_LF) begin
            res = PH_HHASH;
        end else if (ph == PH_HHASH && b == fcd_pkg::CH_START) begin
            res = PH_LEN;
        end
        return res;
    endfunction

    // Hold input while the queue is full or the bank to fill still drains
    assign o_stall = i_q_full || (r_phase == PH_BODY && r_busy[r_wbank]);
    assign accept  = i_valid && !o_stall;
    assign cnt_inc = r_cnt + fcd_pkg::CNT_W'(1);

    // Parser next state
    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_cnt   = r_cnt;
        n_cr_ok = r_cr_ok;
        n_wbank = r_wbank;
        n_busy  = r_busy;
        o_push  = 1'b0;
        o_cmd   = '{status: fcd_pkg::ST_OK, length: r_len, bank: r_wbank};
        o_wr    = '{we: 1'b0, addr: {r_wbank, r_cnt[fcd_pkg::BODY_AW-1:0]},
                    data: i_rx_byte};
        if (i_rel.valid) begin
            n_busy[i_rel.bank] = 1'b0;
        end
        if (accept) begin
            case (r_phase)
                PH_START: begin
                    if (i_rx_byte == fcd_pkg::CH_START) begin
                        n_phase = PH_LEN;
                    end else begin
                        n_phase = hunt_next(PH_HCR, i_rx_byte);
                    end
                end
                PH_LEN: begin
                    n_len   = i_rx_byte;
                    n_cnt   = '0;
                    n_cr_ok = 1'b0;
                    if (i_rx_byte > 8'(fcd_pkg::MAX_BODY)) begin
                        o_push  = 1'b1;
                        o_cmd   = '{status: fcd_pkg::ST_TOO_LONG, length: i_rx_byte,
                                    bank: r_wbank};
                        n_phase = PH_HCR;
                    end else if (i_rx_byte == 8'd0) begin
                        n_phase = PH_TCR;
                    end else begin
                        n_phase = PH_BODY;
                    end
                end
                PH_BODY: begin
                    o_wr.we = 1'b1;
                    n_cnt   = cnt_inc;
                    if (8'(cnt_inc) >= r_len || cnt_inc == fcd_pkg::CNT_W'(fcd_pkg::MAX_BODY)) begin
                        n_phase = PH_TCR;
                    end
                end
                PH_TCR: begin
                    n_cr_ok = (i_rx_byte == fcd_pkg::CH_CR);
                    n_phase = PH_TLF;
                end
                PH_TLF: begin
                    o_push = 1'b1;
                    if (!(r_cr_ok && i_rx_byte == fcd_pkg::CH_LF)) begin
                        o_cmd = '{status: fcd_pkg::ST_BAD_TRAILER, length: r_len,
                                  bank: r_wbank};
                    end else if (r_len == 8'd0) begin
                        o_cmd = '{status: fcd_pkg::ST_EMPTY, length: 8'd0, bank: r_wbank};
                    end else begin
                        // good frame: hand over the bank and switch to the other one
                        o_cmd            = '{status: fcd_pkg::ST_OK, length: r_len,
                                             bank: r_wbank};
                        n_busy[r_wbank]  = 1'b1;
                        n_wbank          = ~r_wbank;
                    end
                    n_cr_ok = 1'b0;
                    n_cnt   = '0;
                    n_phase = PH_START;
                end
                PH_HCR, PH_HLF, PH_HHASH: begin
                    n_phase = hunt_next(r_phase, i_rx_byte);
                end
                default: begin
                    n_phase = PH_START;
                end
            endcase
        end
    end

    // Parser registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_len   <= '0;
            r_cnt   <= '0;
            r_cr_ok <= 1'b0;
            r_wbank <= 1'b0;
            r_busy  <= '0;
        end else begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
            r_cr_ok <= n_cr_ok;
            r_wbank <= n_wbank;
            r_busy  <= n_busy;
        end
    end

endmodule

// ----- sv/fcd_queue.sv -----
// Small command queue between the parser and the output side.
// Depends on fcd_pkg.

module fcd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  fcd_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output fcd_pkg::t_cmd o_head,
    output logic          o_empty,
    output logic          o_full
);

    fcd_pkg::t_cmd                 r_entry [fcd_pkg::CMDQ_DEPTH];
    logic [fcd_pkg::CMDQ_AW-1:0]   r_wptr, r_rptr;
    logic [fcd_pkg::CMDQ_AW:0]     r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (fcd_pkg::CMDQ_AW + 1)'(fcd_pkg::CMDQ_DEPTH));
    assign o_head  = r_entry[r_rptr];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wptr] <= i_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + fcd_pkg::CMDQ_AW'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + fcd_pkg::CMDQ_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (fcd_pkg::CMDQ_AW + 1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (fcd_pkg::CMDQ_AW + 1)'(1);
            end
        end
    end

endmodule

// ----- sv/fcd_back.sv -----
// Output side: walks queued commands, reads body bytes, drives result registers.
// Depends on fcd_pkg.

module fcd_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  fcd_pkg::t_cmd               i_head,
    input  logic                        i_empty,
    output logic                        o_pop,
    output logic                        o_re,
    output logic [fcd_pkg::RAM_AW-1:0]  o_raddr,
    input  logic [7:0]                  i_rdata,
    output fcd_pkg::t_rel               o_rel,
    input  logic                        i_stall,
    output logic                        o_valid,
    output logic [7:0]                  o_body_byte,
    output logic [4:0]                  o_byte_index,
    output logic                        o_last,
    output logic [1:0]                  o_status,
    output logic [7:0]                  o_frame_length
);

    typedef struct packed {
        logic [4:0]      index;
        logic            last;
        fcd_pkg::t_status status;
        logic [7:0]      length;
    } t_meta;

    logic [fcd_pkg::BODY_AW-1:0] r_idx;
    logic                        r_p_valid;
    t_meta                       r_p_meta;
    logic                        r_o_valid;
    logic [7:0]                  r_o_body;
    t_meta                       r_o_meta;
    logic                        p_move;
    logic                        issue;
    logic                        is_ok;
    logic                        is_last;
    logic [7:0]                  idx8;

    // Read stage advances when the output register is free or being taken
    assign p_move  = r_p_valid && (!r_o_valid || !i_stall);
    assign issue   = !i_empty && (!r_p_valid || p_move);
    assign is_ok   = (i_head.status == fcd_pkg::ST_OK);
    assign idx8    = 8'(r_idx);
    assign is_last = !is_ok || (idx8 + 8'd1 == i_head.length);

    assign o_pop     = issue && is_last;
    assign o_re      = issue && is_ok;
    assign o_raddr   = {i_head.bank, r_idx};
    assign o_rel     = '{valid: issue && is_last && is_ok, bank: i_head.bank};

    // Body index counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (issue) begin
            r_idx <= is_last ? '0 : r_idx + fcd_pkg::BODY_AW'(1);
        end
    end

    // Read stage: metadata alongside the memory read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (issue) begin
            r_p_valid <= 1'b1;
        end else if (p_move) begin
            r_p_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_p_meta <= '{index: is_ok ? idx8[4:0] : 5'd0, last: is_last,
                          status: i_head.status, length: i_head.length};
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (p_move) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_move) begin
            r_o_meta <= r_p_meta;
            r_o_body <= (r_p_meta.status == fcd_pkg::ST_OK) ? i_rdata : 8'd0;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_body_byte    = r_o_body;
    assign o_byte_index   = r_o_meta.index;
    assign o_last         = r_o_meta.last;
    assign o_status       = r_o_meta.status;
    assign o_frame_length = r_o_meta.length;

endmodule

// ----- sv/framed_command_deframer_unit.sv -----
// Top level of the framed command deframer: parser, command queue, output side.
// Depends on fcd_pkg, fcd_ram, fcd_front, fcd_queue, fcd_back.
//
//   Channel   Handshake            Payload
//   input     i_valid / o_stall    i_rx_byte
//   output    o_valid / i_stall    o_body_byte, o_byte_index, o_last, o_status,
//                                  o_frame_length
//
// The parser takes one byte per cycle unless stalled. Results leave one per cycle
// while i_stall is low, through the memory read stage, then the output register.
// Bodies are double banked in one 64-entry RAM; the parser stalls only when the
// queue is full or the bank it must fill is still draining.
// Reset is synchronous and active low; no clearing pass.

module framed_command_deframer_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_rx_byte,
    output logic       o_stall,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_body_byte,
    output logic [4:0] o_byte_index,
    output logic       o_last,
    output logic [1:0] o_status,
    output logic [7:0] o_frame_length
);

    fcd_pkg::t_cmd               push_cmd, head_cmd;
    fcd_pkg::t_wr                wr;
    fcd_pkg::t_rel               rel;
    logic                        push, pop, q_empty, q_full, re;
    logic [fcd_pkg::RAM_AW-1:0]  raddr;
    logic [7:0]                  rdata;

    fcd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_rx_byte (i_rx_byte),
        .o_stall   (o_stall),
        .i_q_full  (q_full),
        .o_push    (push),
        .o_cmd     (push_cmd),
        .o_wr      (wr),
        .i_rel     (rel)
    );

    fcd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    fcd_ram #(
        .WIDTH (8),
        .DEPTH (fcd_pkg::RAM_DEPTH)
    ) u_body_ram (
        .i_clk   (i_clk),
        .i_we    (wr.we),
        .i_waddr (wr.addr),
        .i_wdata (wr.data),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    fcd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head_cmd),
        .i_empty        (q_empty),
        .o_pop          (pop),
        .o_re           (re),
        .o_raddr        (raddr),
        .i_rdata        (rdata),
        .o_rel          (rel),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_body_byte    (o_body_byte),
        .o_byte_index   (o_byte_index),
        .o_last         (o_last),
        .o_status       (o_status),
        .o_frame_length (o_frame_length)
    );

endmodule

// ----- sv/fcd_checker.sv -----
// Port-level checks for the framed command deframer, bound to the top level.
// Depends on fcd_pkg and framed_command_deframer_unit.

module fcd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_body_byte,
    input logic [4:0] o_byte_index,
    input logic       o_last,
    input logic [1:0] o_status,
    input logic [7:0] o_frame_length
);

    // A stalled result stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // Status results are single and carry no body
    a_status_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != fcd_pkg::ST_OK |->
            o_last && o_body_byte == 8'd0 && o_byte_index == 5'd0)
        else $error("status result malformed");

    // Good frames never report a zero length
    a_ok_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == fcd_pkg::ST_OK |-> o_frame_length != 8'd0)
        else $error("good frame with zero length");

    // Empty frame status reports length zero
    a_empty_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == fcd_pkg::ST_EMPTY |-> o_frame_length == 8'd0)
        else $error("empty frame with nonzero length");

    // No result right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind framed_command_deframer_unit fcd_checker u_fcd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_body_byte    (o_body_byte),
    .o_byte_index   (o_byte_index),
    .o_last         (o_last),
    .o_status       (o_status),
    .o_frame_length (o_frame_length)
);
